// File: design/hitp_pkg.sv
// ----------------------------------------------------------------------------
// HTML integer text parser package
// Shared widths, character codes, parse phases, status codes and result type.
// ----------------------------------------------------------------------------
package hitp_pkg;

  localparam int CHAR_W  = 16;
  localparam int MAG_W   = 32;
  localparam int VALUE_W = 33;
  localparam int SUM_W   = 36;

  localparam logic [CHAR_W-1:0] CHAR_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 16'h000A;
  localparam logic [CHAR_W-1:0] CHAR_FF    = 16'h000C;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 16'h000D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 16'h002B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 16'h002D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 16'h0039;

  localparam logic [SUM_W-1:0] SIGNED_LIMIT   = 36'h0_7FFF_FFFF;
  localparam logic [SUM_W-1:0] UNSIGNED_LIMIT = 36'h0_FFFF_FFFF;

  typedef enum logic [4:0] {
    PH_SKIP   = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_AFTER  = 5'b01000,
    PH_FAIL   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NONUM = 2'd1,
    STATUS_OVF   = 2'd2
  } status_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  value;
  } hitp_res_t;

endpackage

// File: design/hitp_if.sv
// ----------------------------------------------------------------------------
// HTML integer text parser channel interfaces
// Valid/ready channels for input characters and for parse results.
// ----------------------------------------------------------------------------
interface hitp_in_if;
  logic                        valid;
  logic                        ready;
  logic [hitp_pkg::CHAR_W-1:0] character;
  logic                        char_present;
  logic                        last_char;

  modport source (output valid, character, char_present, last_char, input ready);
  modport sink (input valid, character, char_present, last_char, output ready);
endinterface

interface hitp_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [hitp_pkg::VALUE_W-1:0] value;

  modport source (output valid, status, value, input ready);
  modport sink (input valid, status, value, output ready);
endinterface

// File: design/hitp_parse.sv
// ----------------------------------------------------------------------------
// HTML integer text parser state and step logic
// Holds the per-string parse state and forms the result of the current item.
// ----------------------------------------------------------------------------
module hitp_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [hitp_pkg::CHAR_W-1:0] character,
  input  logic                        char_present,
  input  logic                        last_char,
  input  logic                        signed_mode,
  output hitp_pkg::hitp_res_t         res
);
  import hitp_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic               ovf_r, ovf_nxt;

  logic               is_space;
  logic               is_digit;
  logic               is_sign;
  logic [SUM_W-1:0]   limit;
  logic [SUM_W-1:0]   sum;
  logic               sum_ovf;

  assign is_space = character inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_FF, CHAR_CR};
  assign is_digit = character inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_sign  = (character == CHAR_PLUS) || ((character == CHAR_MINUS) && signed_mode);
  assign limit    = signed_mode ? SIGNED_LIMIT : UNSIGNED_LIMIT;
  assign sum      = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1)
                  + {32'b0, character[3:0]};
  assign sum_ovf  = sum > limit;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ovf_nxt   = ovf_r;
    if (char_present) begin
      case (phase_r)
        PH_SKIP: begin
          if (is_space) begin
            phase_nxt = PH_SKIP;
          end else if (is_sign) begin
            neg_nxt   = (character == CHAR_MINUS);
            phase_nxt = PH_SIGN;
          end else if (is_digit) begin
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_SIGN: begin
          phase_nxt = is_digit ? PH_DIGITS : PH_FAIL;
        end
        PH_DIGITS: begin
          if (!is_digit) begin
            phase_nxt = PH_AFTER;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
      if (is_digit && !ovf_r && (phase_r == PH_SKIP || phase_r == PH_SIGN ||
                                 phase_r == PH_DIGITS)) begin
        if (sum_ovf) begin
          ovf_nxt = 1'b1;
        end else begin
          mag_nxt = sum[MAG_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res.value = '0;
    if (phase_nxt != PH_DIGITS && phase_nxt != PH_AFTER) begin
      res.status = STATUS_NONUM;
    end else if (ovf_nxt || ({4'b0, mag_nxt} > limit)) begin
      res.status = STATUS_OVF;
    end else begin
      res.status = STATUS_OK;
      res.value  = neg_nxt ? (~{1'b0, mag_nxt}) + 33'd1 : {1'b0, mag_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (step_en) begin
      if (last_char) begin
        phase_r <= PH_SKIP;
        neg_r   <= 1'b0;
        mag_r   <= '0;
        ovf_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        mag_r   <= mag_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  property p_fail_sticky;
    @(posedge clk) disable iff (!rst_n)
      (phase_r == PH_FAIL) && !(step_en && last_char) |=> phase_r == PH_FAIL;
  endproperty
  a_fail_sticky: assert property (p_fail_sticky) else $error("failed phase left mid-string");

  property p_ovf_freezes_mag;
    @(posedge clk) disable iff (!rst_n)
      ovf_r && !(step_en && last_char) |=> $stable(mag_r);
  endproperty
  a_ovf_freezes_mag: assert property (p_ovf_freezes_mag) else $error("magnitude moved after overflow");

endmodule

// File: design/html_integer_text_parser_top.sv
// ----------------------------------------------------------------------------
// HTML integer text parser
// Parses a UTF-16 string, one character per item, into a 33-bit integer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake       Payload
//  in_chan   sink       valid / ready   character, char_present, last_char
//  out_chan  source     valid / ready   status, value
//  cfg_*     sink       cfg_wr_en       cfg_wr_data (signed_mode)
//
// Takes one item per cycle unless a last item stalls; results are registered from stage s1.
// The rate is set by the combinational multiply-by-ten accumulate and limit compare.
// Reset is synchronous and clears the parse state; signed_mode resets to 1.
// A stalled result holds the input register only when that register carries a last item.
// ----------------------------------------------------------------------------
module html_integer_text_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  hitp_in_if.sink    in_chan,
  hitp_out_if.source out_chan
);
  import hitp_pkg::*;

  logic                 signed_mode_r;
  logic                 s1_valid_r;
  logic [CHAR_W-1:0]    s1_char_r;
  logic                 s1_present_r;
  logic                 s1_last_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [VALUE_W-1:0]   out_value_r;

  logic                 out_free;
  logic                 s1_fire;
  logic                 in_fire;
  hitp_res_t            res;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      signed_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r    <= in_chan.character;
      s1_present_r <= in_chan.char_present;
      s1_last_r    <= in_chan.last_char;
    end
  end

  hitp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_fire),
    .character    (s1_char_r),
    .char_present (s1_present_r),
    .last_char    (s1_last_r),
    .signed_mode  (signed_mode_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_status_r <= res.status;
      out_value_r  <= res.value;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.value  = out_value_r;

  property p_result_from_last;
    @(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> $past(s1_fire && s1_last_r);
  endproperty
  a_result_from_last: assert property (p_result_from_last) else $error("result without last item");

  property p_no_result_lost;
    @(posedge clk) disable iff (!rst_n)
      s1_fire && s1_last_r |-> !out_valid_r || out_chan.ready;
  endproperty
  a_no_result_lost: assert property (p_no_result_lost) else $error("pending result overwritten");

  property p_bad_status_zero;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r && (out_status_r != STATUS_OK) |-> out_value_r == '0;
  endproperty
  a_bad_status_zero: assert property (p_bad_status_zero) else $error("nonzero value on failure");

  property p_stage_holds;
    @(posedge clk) disable iff (!rst_n)
      s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_char_r) && $stable(s1_last_r);
  endproperty
  a_stage_holds: assert property (p_stage_holds) else $error("stalled item lost");

endmodule
